// ----- design/rcsw_pkg.sv -----
// ----------------------------------------------------------------------------
// rcsw_pkg
// Shared types and codes for the RTS/CTS stop-and-wait link controller.
// ----------------------------------------------------------------------------
package rcsw_pkg;

  // Field widths
  localparam int unsigned ActionW   = 3;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CommandW  = 3;
  localparam int unsigned AttemptW  = 4;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 16;

  // Register reset values
  localparam logic [AttemptW-1:0] MaxAttemptsReset  = 4'd3;
  localparam logic [TicksW-1:0]   TimeoutTicksReset = 16'd700;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_MAX_ATTEMPTS  = 1'd0,
    REG_TIMEOUT_TICKS = 1'd1
  } reg_index_t;

  // Input actions
  typedef enum logic [ActionW-1:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_CTS   = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_RTS   = 3'd4,
    ACT_DATA  = 3'd5
  } action_t;

  // Commands to the framer
  typedef enum logic [CommandW-1:0] {
    CMD_NONE     = 3'd0,
    CMD_RTS      = 3'd1,
    CMD_DATA     = 3'd2,
    CMD_CTS      = 3'd3,
    CMD_DONE     = 3'd4,
    CMD_FAILED   = 3'd5,
    CMD_RECEIVED = 3'd6,
    CMD_RESP_TO  = 3'd7
  } command_t;

  // Link phase
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_CTS  = 2'd1,
    PH_WAIT_ACK  = 2'd2,
    PH_WAIT_DATA = 2'd3
  } phase_t;

  // Event latches
  typedef struct packed {
    logic data;
    logic rts;
    logic ack;
    logic cts;
  } events_t;

  // One result item as it leaves the controller
  typedef struct packed {
    command_t          command;
    logic [CountW-1:0] packet_index;
    logic              busy_res;
  } result_t;

endpackage

// ----- design/rcsw_if.sv -----
// ----------------------------------------------------------------------------
// rcsw_if
// Valid/ready channels for link events in and framer commands out.
// ----------------------------------------------------------------------------
interface rcsw_in_if import rcsw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ActionW-1:0] action;
  logic [CountW-1:0]  packet_count;

  modport source (output valid, output action, output packet_count, input ready);
  modport sink   (input valid, input action, input packet_count, output ready);
endinterface

interface rcsw_out_if import rcsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CommandW-1:0] command;
  logic [CountW-1:0]   packet_index;
  logic                busy_res;

  modport source (output valid, output command, output packet_index, output busy_res,
                  input ready);
  modport sink   (input valid, input command, input packet_index, input busy_res,
                  output ready);
endinterface

// ----- design/rcsw_core.sv -----
// ----------------------------------------------------------------------------
// rcsw_core
// Link state, configuration registers and the per-event update logic.
// ----------------------------------------------------------------------------
module rcsw_core
  import rcsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 accept,
  input  logic [ActionW-1:0]   action,
  input  logic [CountW-1:0]    packet_count,
  output result_t              result
);

  logic [AttemptW-1:0] max_attempts;
  logic [TicksW-1:0]   timeout_ticks;

  phase_t              phase, phase_next;
  logic [AttemptW-1:0] attempt_count, attempt_count_next;
  logic [TicksW-1:0]   wait_ticks, wait_ticks_next;
  logic [CountW-1:0]   current_packet, current_packet_next;
  logic [CountW-1:0]   total_packets, total_packets_next;
  events_t             events, events_next;

  logic [TicksW-1:0]   ticks_inc;
  logic [CountW-1:0]   packet_inc;
  logic                expired;
  logic                give_up;
  command_t            command;
  logic [CountW-1:0]   index;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts  <= MaxAttemptsReset;
      timeout_ticks <= TimeoutTicksReset;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_ATTEMPTS:  max_attempts  <= cfg_data[AttemptW-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Timeout bookkeeping for a tick that finds nothing latched.
  // A zero timeout or attempt limit falls out as one through these compares.
  assign ticks_inc  = wait_ticks + 1'b1;
  assign packet_inc = current_packet + 1'b1;
  assign expired    = !((ticks_inc < timeout_ticks) && (ticks_inc != '0));
  assign give_up    = attempt_count >= max_attempts;

  // Next state and command for one transfer on the input channel
  always_comb begin
    phase_next          = phase;
    attempt_count_next  = attempt_count;
    wait_ticks_next     = wait_ticks;
    current_packet_next = current_packet;
    total_packets_next  = total_packets;
    events_next         = events;
    command             = CMD_NONE;
    index               = '0;

    case (action_t'(action))
      ACT_TICK: begin
        case (phase)
          PH_IDLE: begin
            if (events.rts) begin
              events_next.rts    = 1'b0;
              phase_next         = PH_WAIT_DATA;
              attempt_count_next = AttemptW'(1);
              wait_ticks_next    = '0;
              command            = CMD_CTS;
            end
          end
          PH_WAIT_CTS: begin
            if (events.cts) begin
              events_next.cts     = 1'b0;
              current_packet_next = '0;
              if (total_packets == '0) begin
                phase_next = PH_IDLE;
                command    = CMD_DONE;
              end else begin
                phase_next         = PH_WAIT_ACK;
                attempt_count_next = AttemptW'(1);
                wait_ticks_next    = '0;
                command            = CMD_DATA;
              end
            end else begin
              wait_ticks_next = ticks_inc;
              if (expired && give_up) begin
                phase_next = PH_IDLE;
                command    = CMD_FAILED;
              end else if (expired) begin
                attempt_count_next = attempt_count + 1'b1;
                wait_ticks_next    = '0;
                command            = CMD_RTS;
              end
            end
          end
          PH_WAIT_ACK: begin
            if (events.ack) begin
              events_next.ack     = 1'b0;
              current_packet_next = packet_inc;
              if (packet_inc >= total_packets) begin
                phase_next = PH_IDLE;
                command    = CMD_DONE;
              end else begin
                attempt_count_next = AttemptW'(1);
                wait_ticks_next    = '0;
                command            = CMD_DATA;
                index              = packet_inc;
              end
            end else begin
              wait_ticks_next = ticks_inc;
              if (expired && give_up) begin
                phase_next = PH_IDLE;
                command    = CMD_FAILED;
              end else if (expired) begin
                attempt_count_next = attempt_count + 1'b1;
                wait_ticks_next    = '0;
                command            = CMD_DATA;
                index              = current_packet;
              end
            end
          end
          PH_WAIT_DATA: begin
            if (events.data) begin
              events_next.data = 1'b0;
              phase_next       = PH_IDLE;
              command          = CMD_RECEIVED;
            end else begin
              wait_ticks_next = ticks_inc;
              if (expired && give_up) begin
                phase_next = PH_IDLE;
                command    = CMD_RESP_TO;
              end else if (expired) begin
                attempt_count_next = attempt_count + 1'b1;
                wait_ticks_next    = '0;
                command            = CMD_CTS;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      ACT_START: begin
        if (phase == PH_IDLE) begin
          total_packets_next  = packet_count;
          current_packet_next = '0;
          phase_next          = PH_WAIT_CTS;
          attempt_count_next  = AttemptW'(1);
          wait_ticks_next     = '0;
          command             = CMD_RTS;
        end
      end
      ACT_CTS:  events_next.cts  = 1'b1;
      ACT_ACK:  events_next.ack  = 1'b1;
      ACT_RTS:  events_next.rts  = 1'b1;
      ACT_DATA: events_next.data = 1'b1;
      default: ;
    endcase
  end

  // Result of the item being transferred this cycle
  assign result.command      = command;
  assign result.packet_index = index;
  assign result.busy_res     = (phase_next != PH_IDLE);

  // Link state moves only on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      attempt_count  <= '0;
      wait_ticks     <= '0;
      current_packet <= '0;
      total_packets  <= '0;
      events         <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      attempt_count  <= attempt_count_next;
      wait_ticks     <= wait_ticks_next;
      current_packet <= current_packet_next;
      total_packets  <= total_packets_next;
      events         <= events_next;
    end
  end

  // A start from idle always leads into the wait for CTS.
  a_start_waits_cts: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && action_t'(action) == ACT_START
    |=> phase == PH_WAIT_CTS)
    else $error("start from idle did not enter the CTS wait");

  // Every wait has made at least one send.
  a_wait_has_attempt: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> attempt_count != '0)
    else $error("waiting with no send counted");

  // The state holds while no item is transferred.
  a_hold_without_transfer: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(events) && $stable(wait_ticks))
    else $error("link state moved without a transfer");

  // A packet index is only ever given with a data send.
  a_index_only_with_data: assert property (@(posedge clk) disable iff (rst)
    accept && result.packet_index != '0 |-> result.command == CMD_DATA)
    else $error("packet index given without a data send");

endmodule

// ----- design/rcsw_out_buf.sv -----
// ----------------------------------------------------------------------------
// rcsw_out_buf
// Two-entry output register with a skid stage; it decouples the ready of the
// input side from the ready of the framer.
// ----------------------------------------------------------------------------
module rcsw_out_buf
  import rcsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  output logic       can_push,
  rcsw_out_if.source rsp
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  // Control: the skid stage fills only when the main register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !rsp.ready) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (rsp.ready) begin
      main_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp.ready) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !rsp.ready) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  assign can_push         = !skid_valid;
  assign rsp.valid        = main_valid;
  assign rsp.command      = main_data.command;
  assign rsp.packet_index = main_data.packet_index;
  assign rsp.busy_res     = main_data.busy_res;

  // The skid stage never holds an item ahead of the main register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry without a main entry");

  // A push into a full buffer is never offered.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push while both entries are full");

  // A stalled skid entry moves up as soon as the framer takes the main one.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && rsp.ready |=> main_valid && !skid_valid)
    else $error("skid entry did not move up");

endmodule

// ----- design/rts_cts_stop_and_wait_link.sv -----
// ----------------------------------------------------------------------------
// rts_cts_stop_and_wait_link
// RTS/CTS handshake and stop-and-wait ARQ controller for a half-duplex link.
// ----------------------------------------------------------------------------
// Each accepted item (a tick, a start request or a received-frame event)
// produces exactly one command item, registered in the output buffer. An
// item can be accepted in every cycle while the buffer has a free entry: the
// link state is updated by one level of compare-and-increment logic in the
// cycle of the transfer, and the result is held in a two-entry output buffer,
// so the input stays ready while one result waits for the framer and drops
// only when both entries are full. Configuration writes (max_attempts at
// index 0, timeout_ticks at index 1) are registered and should be made while
// no result is pending.
// ----------------------------------------------------------------------------
module rts_cts_stop_and_wait_link
  import rcsw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  rcsw_in_if.sink              req,
  rcsw_out_if.source           rsp
);

  logic    accept;
  logic    can_push;
  result_t result;

  assign req.ready = can_push;
  assign accept    = req.valid && can_push;

  // Link state and per-event update
  rcsw_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .action       (req.action),
    .packet_count (req.packet_count),
    .result       (result)
  );

  // Result buffering towards the framer
  rcsw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .rsp       (rsp)
  );

endmodule
